// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the blur block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Types and constants shared by the 3x3 box blur modules.
// ----------------------------------------------------------------------------
package bb3_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bb3_in_t;

  typedef struct packed {
    logic [7:0] blur_red;
    logic [7:0] blur_green;
    logic [7:0] blur_blue;
    logic       frame_end;
  } bb3_out_t;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SUM,
    ST_DIV
  } bb3_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // latch the accepted item
    logic wr_pixel;   // write pixel to store, advance input position
    logic rd_start;   // begin the nine-tap read sequence
    logic rd_step;    // advance one tap
    logic div_start;  // start dividers
    logic emit;       // load output register, advance output side
  } bb3_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pix_ok;     // pixel is part of the frame
    logic pix_emit;   // pixel causes an output
    logic flush_emit; // flush causes an output
    logic rd_done;    // last tap data returned, summed at this edge
    logic div_done;
  } bb3_sts_t;

endpackage

// ===== rtl/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2052
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bb3_div.sv =====
// ----------------------------------------------------------------------------
// bb3_div
// Restoring divider, one quotient bit per cycle: floor((2*sum+cnt)/(2*cnt)).
// ----------------------------------------------------------------------------
module bb3_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] sum,
  input  logic [3:0]  cnt,
  output logic [7:0]  quo,
  output logic        done
);

  logic [13:0] rem_r, rem_nxt;
  logic [13:0] num_r, num_nxt;
  logic [4:0]  den_r, den_nxt;
  logic [7:0]  q_r, q_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic [13:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    trial    = {rem_r[12:0], num_r[13]};
    if (start) begin
      num_nxt  = {1'b0, sum, 1'b0} + 14'(cnt);
      den_nxt  = {cnt, 1'b0};
      rem_nxt  = '0;
      q_nxt    = '0;
      bit_nxt  = 4'd14;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[12:0], 1'b0};
      if (trial >= 14'(den_r)) begin
        rem_nxt = trial - 14'(den_r);
        q_nxt   = {q_r[6:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[6:0], 1'b0};
      end
      bit_nxt = bit_r - 4'd1;
      if (bit_r == 4'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign quo  = q_r;
  assign done = !busy_r && !start;

endmodule

// ===== rtl/bb3_datapath.sv =====
// ----------------------------------------------------------------------------
// bb3_datapath
// Position counters, pixel ring store, tap accumulator and dividers.
// ----------------------------------------------------------------------------
module bb3_datapath import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [23:0] cfg_wdata,
  input  bb3_in_t  in_item,
  input  bb3_cmd_t cmd,
  output bb3_sts_t sts,
  output bb3_out_t out_item
);

  localparam int DEPTH = 2 * MAX_WIDTH + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int TW    = WW + HW;

  logic [WW-1:0] fw_r;
  logic [HW-1:0] fh_r;
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [WW:0]   pend_r;
  logic [TW-1:0] out_idx_r;    // raster index of next output
  logic [AW-1:0] wslot_r;      // ring slot of next input
  logic [AW-1:0] oslot_r;      // ring slot of next output
  bb3_in_t       item_r;

  logic [10:0] wv;
  logic [12:0] hv;
  logic [WW-1:0] fw_val;
  logic [HW-1:0] fh_val;
  logic [TW-1:0] total;
  logic complete;

  assign wv = cfg_wdata[10:0];
  assign hv = cfg_wdata[12:0];

  always_comb begin
    if (wv == 11'd0) fw_val = WW'(1);
    else if (32'(wv) > MAX_WIDTH) fw_val = WW'(MAX_WIDTH);
    else fw_val = WW'(wv);
    if (hv == 13'd0) fh_val = HW'(1);
    else if (32'(hv) > MAX_HEIGHT) fh_val = HW'(MAX_HEIGHT);
    else fh_val = HW'(hv);
  end

  // frame size product, registered after config
  logic [TW-1:0] total_r;
  always_ff @(posedge clk) begin
    total_r <= TW'(fw_r) * TW'(fh_r);
  end
  assign total = total_r;

  assign complete = (out_idx_r + TW'(pend_r)) >= total;

  assign sts.pix_ok     = !complete;
  assign sts.pix_emit   = (pend_r + 1'b1) >= ((WW+1)'(fw_r) + 2);
  assign sts.flush_emit = complete && (pend_r != '0);

  // ---------------- neighbourhood geometry ----------------
  logic last_out;
  logic has_up, has_dn, has_lf, has_rt;
  assign last_out = (32'(out_row_r) == 32'(fh_r) - 1) && (32'(out_col_r) == 32'(fw_r) - 1);
  assign has_up = out_row_r != '0;
  assign has_dn = (32'(out_row_r) + 1) < 32'(fh_r);
  assign has_lf = out_col_r != '0;
  assign has_rt = (32'(out_col_r) + 1) < 32'(fw_r);

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] s, input logic signed [AW+1:0] d);
    logic signed [AW+2:0] t;
    t = $signed({3'b000, s}) + (AW+3)'(d);
    if (t < 0) t = t + (AW+3)'(DEPTH);
    else if (t >= (AW+3)'(DEPTH)) t = t - (AW+3)'(DEPTH);
    return t[AW-1:0];
  endfunction

  // tap walk: dr, dc in -1..1
  logic [3:0]  tap_r;
  logic [3:0]  tap_d_r;     // tap whose data returns this cycle
  logic        tap_v_r;
  logic        tap_in_r;    // returning tap inside frame
  logic [11:0] sr_r, sg_r, sb_r;
  logic [3:0]  cnt_r;
  logic [AW-1:0] raddr;
  logic [23:0] rdata;
  logic signed [1:0] dr, dc;
  logic tap_in;
  logic signed [AW+1:0] off;

  always_comb begin
    // taps walk the window row by row, top left first
    unique case (tap_r)
      4'd0:    begin dr = -2'sd1; dc = -2'sd1; end
      4'd1:    begin dr = -2'sd1; dc =  2'sd0; end
      4'd2:    begin dr = -2'sd1; dc =  2'sd1; end
      4'd3:    begin dr =  2'sd0; dc = -2'sd1; end
      4'd4:    begin dr =  2'sd0; dc =  2'sd0; end
      4'd5:    begin dr =  2'sd0; dc =  2'sd1; end
      4'd6:    begin dr =  2'sd1; dc = -2'sd1; end
      4'd7:    begin dr =  2'sd1; dc =  2'sd0; end
      default: begin dr =  2'sd1; dc =  2'sd1; end
    endcase
    tap_in = !((dr < 0 && !has_up) || (dr > 0 && !has_dn) ||
               (dc < 0 && !has_lf) || (dc > 0 && !has_rt));
    off = (AW+2)'(dc);
    if (dr < 0) off = off - (AW+2)'(fw_r);
    else if (dr > 0) off = off + (AW+2)'(fw_r);
    raddr = slot_add(oslot_r, off);
  end

  assign sts.rd_done = tap_v_r && (tap_d_r == 4'd8);

  bb3_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_pixel),
    .waddr (wslot_r),
    .wdata ({item_r.red, item_r.green, item_r.blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic d0, d1, d2;
  logic [7:0] q0, q1, q2;
  bb3_div u_div_r (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .sum(sr_r),
                   .cnt(cnt_r), .quo(q0), .done(d0));
  bb3_div u_div_g (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .sum(sg_r),
                   .cnt(cnt_r), .quo(q1), .done(d1));
  bb3_div u_div_b (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .sum(sb_r),
                   .cnt(cnt_r), .quo(q2), .done(d2));
  assign sts.div_done = d0 && d1 && d2;

  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_item;
    if (cmd.rd_start) begin
      sr_r <= '0; sg_r <= '0; sb_r <= '0; cnt_r <= '0;
    end else if (tap_v_r && tap_in_r) begin
      sr_r  <= sr_r + 12'(rdata[23:16]);
      sg_r  <= sg_r + 12'(rdata[15:8]);
      sb_r  <= sb_r + 12'(rdata[7:0]);
      cnt_r <= cnt_r + 4'd1;
    end
    if (cmd.emit) begin
      out_item.blur_red   <= q0;
      out_item.blur_green <= q1;
      out_item.blur_blue  <= q2;
      out_item.frame_end  <= last_out;
    end
    tap_d_r  <= tap_r;
    tap_in_r <= tap_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
      fh_r <= HW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
      pend_r <= '0; out_idx_r <= '0; wslot_r <= '0; oslot_r <= '0;
      tap_r <= '0; tap_v_r <= 1'b0;
    end else begin
      tap_v_r <= 1'b0;
      if (cmd.rd_start) begin
        tap_r   <= '0;
      end else if (cmd.rd_step) begin
        tap_v_r <= 1'b1;
        if (tap_r != 4'd8) tap_r <= tap_r + 4'd1;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) fw_r <= fw_val;
        else fh_r <= fh_val;
        in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
        pend_r <= '0; out_idx_r <= '0; wslot_r <= '0; oslot_r <= '0;
      end else begin
        if (cmd.wr_pixel) begin
          wslot_r <= slot_add(wslot_r, (AW+2)'(1));
          if (32'(in_col_r) + 1 >= 32'(fw_r)) begin
            in_col_r <= '0;
            if (32'(in_row_r) + 1 >= 32'(fh_r)) in_row_r <= '0;
            else in_row_r <= in_row_r + 1'b1;
          end else begin
            in_col_r <= in_col_r + 1'b1;
          end
        end
        if (cmd.emit && last_out) begin
          in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
          pend_r <= '0; out_idx_r <= '0; wslot_r <= '0; oslot_r <= '0;
        end else if (cmd.emit) begin
          pend_r    <= pend_r + (cmd.wr_pixel ? 1'b1 : 1'b0) - 1'b1;
          out_idx_r <= out_idx_r + 1'b1;
          oslot_r   <= slot_add(oslot_r, (AW+2)'(1));
          if (32'(out_col_r) + 1 >= 32'(fw_r)) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end else if (cmd.wr_pixel) begin
          pend_r <= pend_r + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bb3_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: accept, store, read nine taps, divide, present the result.
// ----------------------------------------------------------------------------
module bb3_ctrl import bb3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_action,
  input  logic     out_ready,
  input  bb3_sts_t sts,
  output logic     in_ready,
  output logic     out_valid,
  output logic     busy,
  output bb3_cmd_t cmd
);

  bb3_state_t state_r, state_nxt;
  logic act_r, act_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= ACT_PIXEL;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.take  = 1'b1;
          act_nxt   = in_action;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (act_r == ACT_FLUSH) begin
          if (sts.flush_emit) begin
            cmd.rd_start = 1'b1;
            state_nxt    = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (sts.pix_ok) begin
          // output decision uses pending count before this write
          if (sts.pix_emit) begin
            cmd.rd_start = 1'b1;
            state_nxt    = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
          // store the pixel first; it is the lower right tap of the output
          cmd.wr_pixel = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
        if (sts.rd_done) begin
          cmd.rd_step = 1'b0;
          state_nxt   = ST_SUM;
        end
      end
      ST_SUM: begin
        // sums now hold every tap that lies inside the frame
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done && !ov_nxt) begin
          cmd.emit  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign busy      = (state_r != ST_IDLE);

endmodule

// ===== rtl/box_blur_3x3.sv =====
// A result passes the states write (store a pixel), read (nine RAM taps and their data
//   return), sum, a 14-step divide and emit, which loads the output register; a held
//   result stalls the emit. Items are taken only while idle, one at a time; the serial
//   tap walk over the single RAM read port and the bit-serial dividers set the pace.
// Reset: synchronous active low rst_n; size registers go to 1024x1024, capped at
//   MAX_WIDTH and MAX_HEIGHT, counters to frame start. The pixel store is not cleared;
//   its data is summed only where written this frame.
// ----------------------------------------------------------------------------
// box_blur_3x3
// Streaming 3x3 box blur over RGB frames with edge clipping and rounding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module box_blur_3x3 import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bb3_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output bb3_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  bb3_cmd_t cmd;
  bb3_sts_t sts;
  logic     busy;
  logic     in_fire;
  logic     cfg_we;

  // config accepted any time; written only while idle by contract
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign in_fire   = in_valid && in_ready;

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_data.action),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .busy      (busy),
    .cmd       (cmd)
  );

  bb3_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index[0]),
    .cfg_wdata (cfg_data),
    .in_item   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_data)
  );

  // a result is loaded only when the output register is free or draining
  `ASSERT_CLK(a_emit_free, clk, rst_n, cmd.emit |-> (!out_valid || out_ready), "emit overrun")
  // no new transaction while the sequencer works
  `ASSERT_CLK(a_no_take_busy, clk, rst_n, busy |-> !in_ready, "accept while busy")
  // a held result stays
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")

endmodule
